### rtl/wred_pkg.sv
// shared types and constants of the windowed ramp event detector
package wred_pkg;

   localparam int TIME_W     = 32;
   localparam int VALUE_W    = 32;
   localparam int WIN_W      = 24;
   localparam int OP_W       = 3;
   localparam int STATUS_W   = 2;
   localparam int ALU_W      = 34;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   // configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_EXACT_MODE    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_SECS   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESH_OP     = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESH_VALUE  = 2'd3;

   // threshold operator codes
   localparam logic [OP_W-1:0] OP_LT = 3'd0;
   localparam logic [OP_W-1:0] OP_LE = 3'd1;
   localparam logic [OP_W-1:0] OP_EQ = 3'd2;
   localparam logic [OP_W-1:0] OP_NE = 3'd3;
   localparam logic [OP_W-1:0] OP_GT = 3'd4;
   localparam logic [OP_W-1:0] OP_GE = 3'd5;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_UNDEF    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_RAMP  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RAMP     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_OP_ERROR = 2'd3;

   // reset values of the configuration registers
   localparam logic [WIN_W-1:0]   WINDOW_RESET = 24'd3600;
   localparam logic [OP_W-1:0]    OP_RESET     = OP_GT;

   // one stored history entry
   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] value;
      logic [TIME_W-1:0]         stamp;
   } hist_entry_type;

   // operands of the shared subtract and compare unit: (a - b) against c
   typedef struct packed {
      logic signed [ALU_W-1:0] a;
      logic signed [ALU_W-1:0] b;
      logic signed [ALU_W-1:0] c;
   } alu_req_type;

   typedef struct packed {
      logic lt;
      logic eq;
   } alu_rsp_type;

endpackage

### rtl/wred_alu.sv
// shared subtract and compare unit: difference of two operands against a limit
module wred_alu (
   input  wred_pkg::alu_req_type req,
   output wred_pkg::alu_rsp_type rsp
);

   logic signed [wred_pkg::ALU_W-1:0] diff;

   // difference, then signed compare against the limit
   assign diff   = req.a - req.b;
   assign rsp.lt = (diff < req.c);
   assign rsp.eq = (diff == req.c);

endmodule

### rtl/windowed_ramp_event_detector.sv
// top level of the windowed ramp event detector: history ring, scan sequencer, result register
//
//  channel  | direction | ports                          | contents
//  ---------+-----------+--------------------------------+-------------------------------------
//  req      | in        | req_tvalid/tready/tdata/tuser  | sample_time, sample_value, value_valid
//  rsp      | out       | rsp_tvalid/tready/tdata/tuser  | prior_value, ramp_status, prior_valid
//  csr      | in        | csr_we/csr_addr/csr_wdata      | exact_mode, window_seconds, thresh_op,
//           |           |                                | thresh_value
//
// each sample makes a history read per stored entry on the single read port and shared
// compare unit (no reads when an operator error skips the scan), then a scan step folding
// the last read, evaluate-and-store, result hand-off and the idle accept step. reset clears
// control state and configuration; the history memory needs no clearing since only written
// entries are scanned. a stalled rsp side holds the result in the output register while the
// next sample is accepted and scanned.
module windowed_ramp_event_detector #(
   parameter int HISTORY_DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   // req transaction
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [63:0]                        req_tdata,  // [31:0] sample_time, [63:32] sample_value
   input  logic                               req_tuser,  // [0] value_valid
   // rsp transaction
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [31:0]                        rsp_tdata,  // [31:0] prior_value
   output logic [2:0]                         rsp_tuser,  // [1:0] ramp_status, [2] prior_valid
   // configuration writes
   input  logic                               csr_we,
   input  logic [wred_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [wred_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W = IDX_W + 2;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

   // sequencer state codes
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_EVAL = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   // configuration registers
   logic                                  exact_ff, exact_in;
   logic [wred_pkg::WIN_W-1:0]            window_ff, window_in;
   logic [wred_pkg::OP_W-1:0]             op_ff, op_in;
   logic signed [wred_pkg::VALUE_W-1:0]   thresh_ff, thresh_in;

   // sequencer and ring control
   logic [1:0]                            state_ff, state_in;
   logic [IDX_W-1:0]                      wr_idx_ff, wr_idx_in;
   logic [CNT_W-1:0]                      fill_ff, fill_in;
   logic [IDX_W-1:0]                      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]                      remain_ff, remain_in;
   logic                                  pend_ff, pend_in;

   // current sample and scan result
   logic [wred_pkg::TIME_W-1:0]           cur_time_ff, cur_time_in;
   logic signed [wred_pkg::VALUE_W-1:0]   cur_value_ff, cur_value_in;
   logic                                  cur_ok_ff, cur_ok_in;
   logic                                  found_ff, found_in;
   logic signed [wred_pkg::VALUE_W-1:0]   prior_ff, prior_in;
   logic [wred_pkg::STATUS_W-1:0]         status_ff, status_in;

   // output register
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [wred_pkg::STATUS_W-1:0]         rsp_status_ff, rsp_status_in;
   logic signed [wred_pkg::VALUE_W-1:0]   rsp_prior_ff, rsp_prior_in;
   logic                                  rsp_pvalid_ff, rsp_pvalid_in;

   // history memory and its registered read data
   wred_pkg::hist_entry_type              hist_mem [HISTORY_DEPTH];
   wred_pkg::hist_entry_type              rd_q_ff;
   wred_pkg::hist_entry_type              wr_entry;

   logic                                  req_fire;
   logic                                  want_min, want_max, op_err;
   logic [SUM_W-1:0]                      oldest_sum;
   logic [IDX_W-1:0]                      oldest_idx;
   logic                                  cmp_hit;
   logic                                  better;
   logic                                  out_load;

   wred_pkg::alu_req_type                 alu_req;
   wred_pkg::alu_rsp_type                 alu_rsp;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   // operator decode
   assign want_min = (op_ff == wred_pkg::OP_GT) || (op_ff == wred_pkg::OP_GE);
   assign want_max = (op_ff == wred_pkg::OP_LT) || (op_ff == wred_pkg::OP_LE);
   assign op_err   = (op_ff > wred_pkg::OP_GE) || (!exact_ff && !want_min && !want_max);

   // oldest stored entry: write index minus fill count, wrapped once
   always_comb begin
      oldest_sum = SUM_W'(wr_idx_ff) + SUM_W'(HISTORY_DEPTH) - SUM_W'(fill_ff);
      if (oldest_sum >= SUM_W'(HISTORY_DEPTH)) begin
         oldest_sum = oldest_sum - SUM_W'(HISTORY_DEPTH);
      end
      oldest_idx = oldest_sum[IDX_W-1:0];
   end

   // shared unit operands: time offset against window while scanning, value ramp otherwise
   always_comb begin
      if (state_ff == S_SCAN) begin
         alu_req.a = {2'b00, cur_time_ff};
         alu_req.b = {2'b00, rd_q_ff.stamp};
         alu_req.c = {{(wred_pkg::ALU_W - wred_pkg::WIN_W){1'b0}}, window_ff};
      end else begin
         alu_req.a = {{2{cur_value_ff[wred_pkg::VALUE_W-1]}}, cur_value_ff};
         alu_req.b = {{2{prior_ff[wred_pkg::VALUE_W-1]}}, prior_ff};
         alu_req.c = {{2{thresh_ff[wred_pkg::VALUE_W-1]}}, thresh_ff};
      end
   end

   wred_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   // threshold operator applied to the shared unit's flags
   always_comb begin
      unique case (op_ff)
         wred_pkg::OP_LT: cmp_hit = alu_rsp.lt;
         wred_pkg::OP_LE: cmp_hit = alu_rsp.lt || alu_rsp.eq;
         wred_pkg::OP_EQ: cmp_hit = alu_rsp.eq;
         wred_pkg::OP_NE: cmp_hit = !alu_rsp.eq;
         wred_pkg::OP_GT: cmp_hit = !alu_rsp.lt && !alu_rsp.eq;
         default:         cmp_hit = !alu_rsp.lt;
      endcase
   end

   // window extreme: entry value beats the running prior
   assign better = !found_ff
                   || (want_min && (rd_q_ff.value < prior_ff))
                   || (want_max && (rd_q_ff.value > prior_ff));

   assign out_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   assign wr_entry.stamp = cur_time_ff;
   assign wr_entry.value = cur_value_ff;
   assign wr_entry.valid = cur_ok_ff;

   // configuration write decode
   always_comb begin
      exact_in  = exact_ff;
      window_in = window_ff;
      op_in     = op_ff;
      thresh_in = thresh_ff;
      if (csr_we) begin
         unique case (csr_addr)
            wred_pkg::CSR_EXACT_MODE:   exact_in  = csr_wdata[0];
            wred_pkg::CSR_WINDOW_SECS:  window_in = csr_wdata[wred_pkg::WIN_W-1:0];
            wred_pkg::CSR_THRESH_OP:    op_in     = csr_wdata[wred_pkg::OP_W-1:0];
            default:                    thresh_in = csr_wdata[wred_pkg::VALUE_W-1:0];
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      wr_idx_in    = wr_idx_ff;
      fill_in      = fill_ff;
      rd_ptr_in    = rd_ptr_ff;
      remain_in    = remain_ff;
      pend_in      = 1'b0;
      cur_time_in  = cur_time_ff;
      cur_value_in = cur_value_ff;
      cur_ok_in    = cur_ok_ff;
      found_in     = found_ff;
      prior_in     = prior_ff;
      status_in    = status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cur_time_in  = req_tdata[31:0];
               cur_value_in = req_tdata[63:32];
               cur_ok_in    = req_tuser;
               found_in     = 1'b0;
               prior_in     = '0;
               rd_ptr_in    = oldest_idx;
               remain_in    = op_err ? '0 : fill_ff;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            // issue one memory read per stored entry
            if (remain_ff != '0) begin
               pend_in   = 1'b1;
               remain_in = remain_ff - CNT_W'(1);
               rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + IDX_W'(1);
            end else begin
               state_in = S_EVAL;
            end
            // fold the entry read in the previous cycle
            if (pend_ff) begin
               if (exact_ff) begin
                  if (alu_rsp.eq) begin
                     found_in = rd_q_ff.valid;
                     prior_in = rd_q_ff.valid ? rd_q_ff.value : '0;
                  end
               end else if ((alu_rsp.lt || alu_rsp.eq) && rd_q_ff.valid && better) begin
                  found_in = 1'b1;
                  prior_in = rd_q_ff.value;
               end
            end
         end
         S_EVAL: begin
            priority if (op_err) begin
               status_in = wred_pkg::STATUS_OP_ERROR;
            end else if (!cur_ok_ff || !found_ff) begin
               status_in = wred_pkg::STATUS_UNDEF;
            end else begin
               status_in = cmp_hit ? wred_pkg::STATUS_RAMP : wred_pkg::STATUS_NO_RAMP;
            end
            // the sample enters the ring
            wr_idx_in = (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + IDX_W'(1);
            if (fill_ff != CNT_W'(HISTORY_DEPTH)) begin
               fill_in = fill_ff + CNT_W'(1);
            end
            state_in = S_DONE;
         end
         default: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_prior_in  = rsp_prior_ff;
      rsp_pvalid_in = rsp_pvalid_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_prior_in  = prior_ff;
         rsp_pvalid_in = found_ff;
      end else if (rsp_tready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         exact_ff     <= 1'b0;
         window_ff    <= wred_pkg::WINDOW_RESET;
         op_ff        <= wred_pkg::OP_RESET;
         thresh_ff    <= '0;
         state_ff     <= S_IDLE;
         wr_idx_ff    <= '0;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         exact_ff     <= exact_in;
         window_ff    <= window_in;
         op_ff        <= op_in;
         thresh_ff    <= thresh_in;
         state_ff     <= state_in;
         wr_idx_ff    <= wr_idx_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_ptr_ff     <= rd_ptr_in;
      cur_time_ff   <= cur_time_in;
      cur_value_ff  <= cur_value_in;
      cur_ok_ff     <= cur_ok_in;
      found_ff      <= found_in;
      prior_ff      <= prior_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_prior_ff  <= rsp_prior_in;
      rsp_pvalid_ff <= rsp_pvalid_in;
   end

   // history memory: one registered read per cycle, and a write in the evaluate state
   always_ff @(posedge clock) begin
      if (state_ff == S_EVAL) begin
         hist_mem[wr_idx_ff] <= wr_entry;
      end
      rd_q_ff <= hist_mem[rd_ptr_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_prior_ff;
   assign rsp_tuser  = {rsp_pvalid_ff, rsp_status_ff};

   // checks
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(HISTORY_DEPTH))
      else $error("history fill count above depth");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_SCAN))
      else $error("accepted sample did not start a scan");

   a_read_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == S_SCAN))
      else $error("memory read data pending outside the scan");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result raised without a finished sample");

   a_op_error_no_prior: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_EVAL) && op_err) |-> !found_ff)
      else $error("prior found under an operator error");

endmodule

### test/tb_top.sv
// testbench of the windowed ramp event detector: directed tests, backpressure, random phases
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 64;

   // operator codes the block rejects in every mode
   localparam logic [wred_pkg::OP_W-1:0] OP_RSVD6 = 3'd6;
   localparam logic [wred_pkg::OP_W-1:0] OP_RSVD7 = 3'd7;

   typedef struct {
      logic [wred_pkg::STATUS_W-1:0] status;
      logic [wred_pkg::VALUE_W-1:0]  prior;
      logic                          prior_ok;
   } ramp_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [63:0]                     req_tdata = '0;   // [31:0] sample_time, [63:32] sample_value
   logic                            req_tuser = 1'b0; // [0] value_valid
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [31:0]                     rsp_tdata;        // [31:0] prior_value
   logic [2:0]                      rsp_tuser;        // [1:0] ramp_status, [2] prior_valid
   logic                            csr_we = 1'b0;
   logic [wred_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [wred_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   windowed_ramp_event_detector #(.HISTORY_DEPTH(DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // detector state as the testbench sees it
   logic                                model_exact  = 1'b0;
   logic [wred_pkg::WIN_W-1:0]          model_window = wred_pkg::WINDOW_RESET;
   logic [wred_pkg::OP_W-1:0]           model_op     = wred_pkg::OP_RESET;
   logic signed [wred_pkg::VALUE_W-1:0] model_thresh = '0;
   logic [wred_pkg::TIME_W-1:0]         ring_time  [DEPTH];
   logic signed [wred_pkg::VALUE_W-1:0] ring_value [DEPTH];
   logic                                ring_ok    [DEPTH];
   int                                  ring_wr   = 0;
   int                                  ring_fill = 0;

   ramp_result_type expected_ramps[$];
   int              mismatch_count = 0;

   // idling controls shared by sender, receiver and tests
   int send_gap_max    = 14;
   int recv_gap_max    = 14;
   int hold_off_cycles = 0;

   // random sample generator state
   logic [wred_pkg::TIME_W-1:0]  stim_time  = '0;
   logic [wred_pkg::VALUE_W-1:0] stim_value = '0;
   int unsigned                  stim_unit  = 1;

   initial begin
      forever #4 clock = ~clock;
   end

   // ramp detection of one sample, then the sample goes into the ring
   function automatic ramp_result_type predict_ramp(
         input logic [wred_pkg::TIME_W-1:0]         stamp,
         input logic signed [wred_pkg::VALUE_W-1:0] value,
         input logic                                ok);
      ramp_result_type res;
      logic            want_min, want_max, op_err, found, hit;
      longint          prior, delta, hv, win, diff, thr;
      int              idx;
      want_min = (model_op == wred_pkg::OP_GT) || (model_op == wred_pkg::OP_GE);
      want_max = (model_op == wred_pkg::OP_LT) || (model_op == wred_pkg::OP_LE);
      op_err   = (model_op > wred_pkg::OP_GE) || (!model_exact && !want_min && !want_max);
      found    = 1'b0;
      prior    = 0;
      win      = {40'h0, model_window};
      // scan oldest to newest
      if (!op_err) begin
         idx = (ring_wr + DEPTH - ring_fill) % DEPTH;
         for (int k = 0; k < ring_fill; k++) begin
            delta = {32'h0, stamp};
            delta = delta - {32'h0, ring_time[idx]};
            hv    = longint'(ring_value[idx]);
            if (model_exact) begin
               if (delta == win) begin
                  found = ring_ok[idx];
                  prior = ring_ok[idx] ? hv : 64'sd0;
               end
            end else if (delta <= win && ring_ok[idx]) begin
               if (!found || (want_min && hv < prior) || (want_max && hv > prior)) begin
                  prior = hv;
                  found = 1'b1;
               end
            end
            idx = (idx + 1) % DEPTH;
         end
      end
      // status from the 33-bit difference
      if (op_err) begin
         res.status = wred_pkg::STATUS_OP_ERROR;
      end else if (!ok || !found) begin
         res.status = wred_pkg::STATUS_UNDEF;
      end else begin
         diff = longint'(value);
         diff = diff - prior;
         thr  = longint'(model_thresh);
         case (model_op)
            wred_pkg::OP_LT: hit = diff < thr;
            wred_pkg::OP_LE: hit = diff <= thr;
            wred_pkg::OP_EQ: hit = diff == thr;
            wred_pkg::OP_NE: hit = diff != thr;
            wred_pkg::OP_GT: hit = diff > thr;
            default:         hit = diff >= thr;
         endcase
         res.status = hit ? wred_pkg::STATUS_RAMP : wred_pkg::STATUS_NO_RAMP;
      end
      res.prior    = prior[31:0];
      res.prior_ok = found;
      // store, dropping the oldest when full
      ring_time[ring_wr]  = stamp;
      ring_value[ring_wr] = value;
      ring_ok[ring_wr]    = ok;
      ring_wr = (ring_wr + 1) % DEPTH;
      if (ring_fill < DEPTH) ring_fill++;
      return res;
   endfunction

   // one sample transaction, prediction queued on acceptance
   task automatic send_sample(input logic [wred_pkg::TIME_W-1:0] stamp,
                              input logic [wred_pkg::VALUE_W-1:0] value,
                              input logic ok);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {value, stamp};
      req_tuser  <= ok;
      do @(posedge clock); while (!req_tready);
      expected_ramps.push_back(predict_ramp(stamp, value, ok));
   endtask

   // register write, block idle
   task automatic write_reg(input logic [wred_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [wred_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (addr)
         wred_pkg::CSR_EXACT_MODE:  model_exact  = data[0];
         wred_pkg::CSR_WINDOW_SECS: model_window = data[wred_pkg::WIN_W-1:0];
         wred_pkg::CSR_THRESH_OP:   model_op     = data[wred_pkg::OP_W-1:0];
         default:                   model_thresh = data;
      endcase
   endtask

   // drop valid, drain all results, then let the block settle
   task automatic wait_idle;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_ramps.size() != 0) @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);
   endtask

   // random sample on a time grid so exact offsets and windows are hit often
   task automatic send_random_sample;
      int          sel;
      int          off;
      logic        ok;
      sel = $urandom_range(0, 59);
      if (sel == 0) begin
         stim_time = $urandom;
      end else if (sel == 1) begin
         stim_time = stim_time - $urandom_range(0, 2 * stim_unit);
      end else begin
         stim_time = stim_time + $urandom_range(0, 3) * stim_unit;
      end
      sel = $urandom_range(0, 15);
      if (sel < 4) begin
         stim_value = $urandom;
      end else if (sel == 4) begin
         stim_value = 32'h7FFF_FFFF;
      end else if (sel == 5) begin
         stim_value = 32'h8000_0000;
      end else begin
         off = int'($urandom_range(0, 1 << 19)) - (1 << 18);
         stim_value = stim_value + off;
      end
      ok = ($urandom_range(0, 9) != 0);
      send_sample(stim_time, stim_value, ok);
   endtask

   // reset configuration: window minimum with gt, value extremes, missing data
   task automatic test_reset_defaults;
      send_sample(32'd1000, 32'h0005_0000, 1'b1);
      send_sample(32'd1000, 32'h8000_0000, 1'b1);
      send_sample(32'd2000, 32'h7FFF_FFFF, 1'b1);
      send_sample(32'd2500, 32'h0000_0000, 1'b0);
      send_sample(32'd10000, 32'h0000_0001, 1'b1);
      wait_idle;
   endtask

   // every operator but gt, including the rejected ones, with threshold extremes
   task automatic test_operator_errors;
      write_reg(wred_pkg::CSR_THRESH_OP, {29'h0, wred_pkg::OP_EQ});
      send_sample(32'd11000, 32'h0002_0000, 1'b1);
      wait_idle;
      write_reg(wred_pkg::CSR_THRESH_OP, {29'h0, wred_pkg::OP_NE});
      send_sample(32'd11001, 32'hFFFF_0000, 1'b1);
      wait_idle;
      write_reg(wred_pkg::CSR_THRESH_OP, {29'h0, OP_RSVD6});
      send_sample(32'd11002, 32'h0003_8000, 1'b1);
      wait_idle;
      write_reg(wred_pkg::CSR_THRESH_OP, {29'h0, OP_RSVD7});
      send_sample(32'd11003, 32'h0001_0000, 1'b1);
      wait_idle;
      write_reg(wred_pkg::CSR_EXACT_MODE, 32'h1);
      send_sample(32'd11004, 32'h0001_0000, 1'b1);
      wait_idle;
      write_reg(wred_pkg::CSR_EXACT_MODE, 32'h0);
      write_reg(wred_pkg::CSR_THRESH_OP, {29'h0, wred_pkg::OP_LT});
      write_reg(wred_pkg::CSR_THRESH_VALUE, 32'h7FFF_FFFF);
      send_sample(32'd11010, 32'h8000_0000, 1'b1);
      wait_idle;
      write_reg(wred_pkg::CSR_THRESH_OP, {29'h0, wred_pkg::OP_LE});
      write_reg(wred_pkg::CSR_THRESH_VALUE, 32'h8000_0000);
      send_sample(32'd11011, 32'h0004_0000, 1'b1);
      wait_idle;
      write_reg(wred_pkg::CSR_THRESH_OP, {29'h0, wred_pkg::OP_GE});
      write_reg(wred_pkg::CSR_THRESH_VALUE, 32'h0);
      send_sample(32'd11012, 32'h0004_0000, 1'b1);
      wait_idle;
   endtask

   // exact offset: duplicates with a missing latest, times out of order, zero offset
   task automatic test_exact_offset;
      write_reg(wred_pkg::CSR_EXACT_MODE, 32'h1);
      write_reg(wred_pkg::CSR_WINDOW_SECS, 32'd10);
      send_sample(32'd20000, 32'h0001_0000, 1'b1);
      send_sample(32'd20000, 32'h0002_0000, 1'b0);
      send_sample(32'd20010, 32'h0003_0000, 1'b1);
      send_sample(32'd20005, 32'h0004_0000, 1'b1);
      send_sample(32'd20015, 32'h0009_0000, 1'b1);
      wait_idle;
      write_reg(wred_pkg::CSR_THRESH_OP, {29'h0, wred_pkg::OP_EQ});
      write_reg(wred_pkg::CSR_THRESH_VALUE, 32'h0005_0000);
      send_sample(32'd20025, 32'h000E_0000, 1'b1);
      wait_idle;
      write_reg(wred_pkg::CSR_THRESH_OP, {29'h0, wred_pkg::OP_NE});
      send_sample(32'd20035, 32'h000E_0000, 1'b1);
      wait_idle;
      write_reg(wred_pkg::CSR_WINDOW_SECS, 32'd0);
      send_sample(32'd20035, 32'h000F_0000, 1'b1);
      wait_idle;
   endtask

   // time stamps at both ends with the widest window
   task automatic test_time_extremes;
      write_reg(wred_pkg::CSR_EXACT_MODE, 32'h0);
      write_reg(wred_pkg::CSR_WINDOW_SECS, 32'hFF_FFFF);
      write_reg(wred_pkg::CSR_THRESH_OP, {29'h0, wred_pkg::OP_GT});
      send_sample(32'h0000_0000, 32'h0010_0000, 1'b1);
      send_sample(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
      send_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      wait_idle;
   endtask

   // receiver holds off long while samples keep coming, so the input stalls
   task automatic test_backpressure;
      stim_time = 32'd50000;
      stim_unit = 5000;
      send_gap_max = 0;
      hold_off_cycles = 600;
      repeat (20) send_random_sample;
      send_gap_max = 14;
      wait_idle;
   endtask

   // random configurations, each followed by a run of random samples
   task automatic test_random_phases;
      logic [wred_pkg::CSR_DATA_W-1:0] data;
      logic [wred_pkg::WIN_W-1:0]      window;
      logic [wred_pkg::OP_W-1:0]       op;
      logic signed [31:0]              thresh;
      for (int p = 0; p < 12; p++) begin
         if (p == 0) begin
            window    = '0;
            stim_unit = 1;
         end else if (p == 1) begin
            window    = 24'hFF_FFFF;
            stim_unit = 24'h55_5555;
         end else begin
            stim_unit = $urandom_range(1, 1000);
            window    = wred_pkg::WIN_W'(stim_unit * $urandom_range(1, 6));
         end
         if ($urandom_range(0, 7) == 0) begin
            op = wred_pkg::OP_W'($urandom_range(OP_RSVD6, OP_RSVD7));
         end else begin
            op = wred_pkg::OP_W'($urandom_range(wred_pkg::OP_LT, wred_pkg::OP_GE));
         end
         if (p == 2) thresh = 32'h7FFF_FFFF;
         else if (p == 3) thresh = 32'h8000_0000;
         else if ($urandom_range(0, 3) == 0) thresh = $urandom;
         else thresh = int'($urandom_range(0, 1 << 20)) - (1 << 19);
         // unused upper bits of the write data are random
         data = $urandom;
         data[0] = 1'(p % 2);
         write_reg(wred_pkg::CSR_EXACT_MODE, data);
         data = $urandom;
         data[wred_pkg::WIN_W-1:0] = window;
         write_reg(wred_pkg::CSR_WINDOW_SECS, data);
         data = $urandom;
         data[wred_pkg::OP_W-1:0] = op;
         write_reg(wred_pkg::CSR_THRESH_OP, data);
         write_reg(wred_pkg::CSR_THRESH_VALUE, thresh);
         // every fourth phase runs back to back on both sides
         send_gap_max = (p % 4 == 3) ? 0 : 14;
         recv_gap_max = send_gap_max;
         repeat (120) send_random_sample;
         wait_idle;
      end
      send_gap_max = 14;
      recv_gap_max = 14;
   endtask

   // result receiver and checker
   initial begin
      int              stall;
      ramp_result_type want;
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            stall = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            stall = $urandom_range(0, recv_gap_max);
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (expected_ramps.size() == 0) begin
            $display("%0t: unexpected result status=%0d prior_value=%h prior_valid=%b",
                     $time, rsp_tuser[1:0], rsp_tdata, rsp_tuser[2]);
            mismatch_count++;
         end else begin
            want = expected_ramps.pop_front();
            if (rsp_tuser[1:0] !== want.status) begin
               $display("%0t: ramp_status expected %0d actual %0d",
                        $time, want.status, rsp_tuser[1:0]);
               mismatch_count++;
            end
            if (rsp_tdata !== want.prior) begin
               $display("%0t: prior_value expected %h actual %h", $time, want.prior, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tuser[2] !== want.prior_ok) begin
               $display("%0t: prior_valid expected %b actual %b",
                        $time, want.prior_ok, rsp_tuser[2]);
               mismatch_count++;
            end
         end
      end
   end

   // run limit
   initial begin
      #6_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // test sequence
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults;
      test_operator_errors;
      test_exact_offset;
      test_time_extremes;
      test_backpressure;
      test_random_phases;
      wait_idle;
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
